### src/hfa_pkg.sv
// shared types, constants and codes for the hole fit allocator
`default_nettype none
package hfa_pkg;

    // default sizes of the hole table
    localparam int MAX_HOLES_DEF = 16;
    localparam int SIZE_BITS_DEF = 16;

    // fixed port field widths
    localparam int SLOT_W     = 4;
    localparam int AMOUNT_W   = 16;
    localparam int POLICY_W   = 2;
    localparam int HIU_W      = 5;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FIT_POLICY   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLES_IN_USE = 1'b1;

    // fit policy codes, any other code acts as first fit
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // request type codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_WB,
        S_RESP
    } t_state;

    // table port strobes
    typedef struct packed {
        logic we;
        logic re;
    } t_tbl_ctl;

    // one result word
    typedef struct packed {
        logic                granted;
        logic [SLOT_W-1:0]   chosen_slot;
        logic [AMOUNT_W-1:0] free_left;
    } t_result;

endpackage
`default_nettype wire

### src/hole_fit_allocator_unit.sv
// top level of the hole fit allocator: config registers and table wiring
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready    i_req_type, i_hole_slot, i_amount
//  out       output     o_out_valid / i_out_ready  o_granted, o_chosen_slot, o_free_left
//  cfg       input      i_cfg_we                   i_cfg_addr, i_cfg_data
//
// a load word, or an allocate word with holes_in_use at zero, goes from S_IDLE
// straight to S_RESP; an allocate word scans n = min(holes_in_use, MAX_HOLES)
// entries one a cycle, then drain and write-back, before S_RESP. a word is
// accepted only in S_IDLE, so a new word waits until the last result is registered.
// reset is synchronous and clears control state and config registers, not the table.
// a stalled result holds in the output register; the next word then waits in S_RESP.
`default_nettype none
module hole_fit_allocator_unit #(
    parameter int MAX_HOLES = hfa_pkg::MAX_HOLES_DEF,
    parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire  [hfa_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  wire  [hfa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_req_type,
    input  wire  [hfa_pkg::SLOT_W-1:0]        i_hole_slot,
    input  wire  [hfa_pkg::AMOUNT_W-1:0]      i_amount,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output logic                              o_granted,
    output logic [hfa_pkg::SLOT_W-1:0]        o_chosen_slot,
    output logic [hfa_pkg::AMOUNT_W-1:0]      o_free_left
);
    import hfa_pkg::*;

    localparam int IDX_W = $clog2(MAX_HOLES);

    logic [POLICY_W-1:0]  r_fit_policy;
    logic [HIU_W-1:0]     r_holes_in_use;
    t_tbl_ctl             tbl_ctl;
    logic [IDX_W-1:0]     tbl_waddr;
    logic [SIZE_BITS-1:0] tbl_wdata;
    logic [IDX_W-1:0]     tbl_raddr;
    logic [SIZE_BITS-1:0] tbl_rdata;
    t_result              result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy   <= '0;
            r_holes_in_use <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FIT_POLICY:   r_fit_policy   <= POLICY_W'(i_cfg_data);
                CFG_HOLES_IN_USE: r_holes_in_use <= HIU_W'(i_cfg_data);
            endcase
        end
    end

    // sequencer and compare unit
    hfa_ctrl #(
        .MAX_HOLES (MAX_HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_policy       (r_fit_policy),
        .i_holes_in_use (r_holes_in_use),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_hole_slot    (i_hole_slot),
        .i_amount       (i_amount),
        .o_tbl_ctl      (tbl_ctl),
        .o_waddr        (tbl_waddr),
        .o_wdata        (tbl_wdata),
        .o_raddr        (tbl_raddr),
        .i_rdata        (tbl_rdata),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result       (result)
    );

    // hole table
    hfa_table #(
        .MAX_HOLES (MAX_HOLES),
        .SIZE_BITS (SIZE_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_ctl   (tbl_ctl),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    // result word fields
    assign o_granted     = result.granted;
    assign o_chosen_slot = result.chosen_slot;
    assign o_free_left   = result.free_left;

endmodule
`default_nettype wire

### src/hfa_table.sv
// hole free space table, one write port and one registered read port
`default_nettype none
module hfa_table #(
    parameter int MAX_HOLES = hfa_pkg::MAX_HOLES_DEF,
    parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF,
    localparam int IDX_W = $clog2(MAX_HOLES)
) (
    input  wire                   i_clk,
    input  hfa_pkg::t_tbl_ctl     i_ctl,
    input  wire  [IDX_W-1:0]      i_waddr,
    input  wire  [SIZE_BITS-1:0]  i_wdata,
    input  wire  [IDX_W-1:0]      i_raddr,
    output logic [SIZE_BITS-1:0]  o_rdata
);
    import hfa_pkg::*;

    logic [SIZE_BITS-1:0] r_mem [MAX_HOLES];
    logic [SIZE_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### src/hfa_ctrl.sv
// scan sequencer, shared fit compare unit and result register
`default_nettype none
module hfa_ctrl #(
    parameter int MAX_HOLES = hfa_pkg::MAX_HOLES_DEF,
    parameter int SIZE_BITS = hfa_pkg::SIZE_BITS_DEF,
    localparam int IDX_W = $clog2(MAX_HOLES),
    localparam int CNT_W = $clog2(MAX_HOLES + 1)
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire  [hfa_pkg::POLICY_W-1:0]      i_policy,
    input  wire  [hfa_pkg::HIU_W-1:0]         i_holes_in_use,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire                               i_req_type,
    input  wire  [hfa_pkg::SLOT_W-1:0]        i_hole_slot,
    input  wire  [hfa_pkg::AMOUNT_W-1:0]      i_amount,
    output hfa_pkg::t_tbl_ctl                 o_tbl_ctl,
    output logic [IDX_W-1:0]                  o_waddr,
    output logic [SIZE_BITS-1:0]              o_wdata,
    output logic [IDX_W-1:0]                  o_raddr,
    input  wire  [SIZE_BITS-1:0]              i_rdata,
    output logic                              o_out_valid,
    input  wire                               i_out_ready,
    output hfa_pkg::t_result                  o_result
);
    import hfa_pkg::*;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [SIZE_BITS-1:0] r_req, n_req;
    logic                 r_found, n_found;
    logic [SIZE_BITS-1:0] r_best, n_best;
    logic [IDX_W-1:0]     r_pick, n_pick;
    t_result              r_res, n_res;
    logic                 r_out_vld, n_out_vld;
    t_result              r_out, n_out;

    logic                 in_fire;
    logic                 out_free;
    logic                 slot_ok;
    logic [SIZE_BITS-1:0] amt_s;
    logic [SIZE_BITS-1:0] left;
    logic [31:0]          hiu32;
    logic [CNT_W-1:0]     n_eff;
    logic                 last;
    logic                 fits;
    logic                 better;
    logic                 take;

    // request decode and scan length
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_vld || i_out_ready;
    assign slot_ok  = 32'(i_hole_slot) < MAX_HOLES;
    assign amt_s    = SIZE_BITS'(i_amount);
    assign left     = r_best - r_req;
    assign hiu32    = 32'(i_holes_in_use);
    assign n_eff    = CNT_W'((hiu32 > MAX_HOLES) ? MAX_HOLES : hiu32);
    assign last     = (32'(r_idx) + 32'd1) == 32'(n_eff);

    // shared fit compare unit, strict compare keeps ties at the lower index
    always_comb begin
        fits = i_rdata >= r_req;
        unique case (i_policy)
            POL_BEST:  better = i_rdata < r_best;
            POL_WORST: better = i_rdata > r_best;
            default:   better = 1'b0;
        endcase
        take = r_rd_vld && fits && (!r_found || better);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_req_type == REQ_LOAD || n_eff == '0) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_WB;
            S_WB:    n_state = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake and table port controls
    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_tbl_ctl.we = ((r_state == S_IDLE) && in_fire && i_req_type == REQ_LOAD && slot_ok)
                    || ((r_state == S_WB) && r_found);
        o_tbl_ctl.re = (r_state == S_SCAN);
        o_waddr      = (r_state == S_IDLE) ? IDX_W'(32'(i_hole_slot)) : r_pick;
        o_wdata      = (r_state == S_IDLE) ? amt_s : left;
        o_raddr      = r_idx;
    end

    // datapath next values
    always_comb begin
        n_idx     = r_idx;
        n_req     = r_req;
        n_found   = r_found;
        n_best    = r_best;
        n_pick    = r_pick;
        n_res     = r_res;
        n_out_vld = r_out_vld;
        n_out     = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res   = '0;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_req   = amt_s;
                    if (i_req_type == REQ_LOAD && slot_ok) begin
                        n_res.granted     = 1'b1;
                        n_res.chosen_slot = i_hole_slot;
                        n_res.free_left   = AMOUNT_W'(amt_s);
                    end
                end
            end
            S_SCAN: n_idx = r_idx + 1'b1;
            S_WB: begin
                if (r_found) begin
                    n_res.granted     = 1'b1;
                    n_res.chosen_slot = SLOT_W'(r_pick);
                    n_res.free_left   = AMOUNT_W'(left);
                end
            end
            default: begin
            end
        endcase

        // candidate update from the word read last cycle
        if (take) begin
            n_found = 1'b1;
            n_best  = i_rdata;
            n_pick  = r_rd_idx;
        end

        // result register
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end
        if (r_state == S_RESP && out_free) begin
            n_out_vld = 1'b1;
            n_out     = r_res;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_vld  <= (r_state == S_SCAN);
            r_found   <= n_found;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_rd_idx <= r_idx;
        r_req    <= n_req;
        r_best   <= n_best;
        r_pick   <= n_pick;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_result    = r_out;

    // a refused request reports slot and space as zero
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_result.granted) |->
            (o_result.chosen_slot == '0 && o_result.free_left == '0))
        else $error("refused word carries nonzero slot or space");

    // read data only returns while scanning or draining
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == S_SCAN || r_state == S_DRAIN))
        else $error("table read data outside of a scan");

    // a held candidate always fits the request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_found && (r_state == S_DRAIN || r_state == S_WB)) |-> (r_best >= r_req))
        else $error("candidate hole smaller than request");

    // table writes happen only on a load or at write-back
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tbl_ctl.we |-> (r_state == S_IDLE || r_state == S_WB))
        else $error("table write outside load or write-back");

    // no new word while busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> !o_in_ready || $past(last))
        else $error("ready raised in the middle of a scan");

endmodule
`default_nettype wire
